// ===== rtl/gcfe_pkg.sv =====
// Shared types and constants for the graph coloring conflict counter.
// No dependencies; every other file but gcfe_ram imports this package.

package gcfe_pkg;

    // Field widths of the request and result transactions
    localparam int CMD_W      = 2;
    localparam int VTX_W      = 6;
    localparam int COLOR_W    = 7;
    localparam int VC_W       = 7;
    localparam int CONFLICT_W = 11;
    localparam int DISTINCT_W = 7;

    // Number of distinct color codes tracked by the seen mask
    localparam int COLOR_CODES = 1 << COLOR_W;

    // Saturation limits of the two counts
    localparam logic [CONFLICT_W-1:0] CONFLICT_MAX = '1;
    localparam logic [DISTINCT_W-1:0] DISTINCT_MAX = '1;

    // Reset value of the vertex count register
    localparam logic [VC_W-1:0] VC_RESET = 7'd64;

    // Request command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_EDGE  = 2'd1,
        CMD_COLOR = 2'd2,
        CMD_EVAL  = 2'd3
    } gcfe_cmd_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_RD,
        ST_EDGE_WR,
        ST_EVAL,
        ST_DRAIN
    } gcfe_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_adj;
        logic write_color;
        logic latch_edge;
        logic edge_rd;
        logic edge_wr;
        logic eval_start;
        logic eval_issue;
        logic load_result;
    } gcfe_ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic edge_ok;
        logic last_issue;
        logic pipe_idle;
        logic out_free;
    } gcfe_sts_t;

endpackage

// ===== rtl/gcfe_req_if.sv =====
// Request channel: valid/ready handshake with the command payload.
// Depends on gcfe_pkg for field widths.

interface gcfe_req_if;
    import gcfe_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [VTX_W-1:0]   vertex_a;
    logic [VTX_W-1:0]   vertex_b;
    logic [COLOR_W-1:0] color_value;

    modport source (
        output valid, cmd, vertex_a, vertex_b, color_value,
        input  ready
    );

    modport sink (
        input  valid, cmd, vertex_a, vertex_b, color_value,
        output ready
    );
endinterface

// ===== rtl/gcfe_rsp_if.sv =====
// Result channel: valid/ready handshake with the evaluation scores.
// Depends on gcfe_pkg for field widths.

interface gcfe_rsp_if;
    import gcfe_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CONFLICT_W-1:0] conflict_count;
    logic [DISTINCT_W-1:0] distinct_colors;
    logic                  proper_coloring;

    modport source (
        output valid, conflict_count, distinct_colors, proper_coloring,
        input  ready
    );

    modport sink (
        input  valid, conflict_count, distinct_colors, proper_coloring,
        output ready
    );
endinterface

// ===== rtl/graph_coloring_fitness_eval_core.sv =====
// Graph coloring conflict counter: usage notes.
//
// Channels: req (sink) carries cmd, vertex_a, vertex_b and color_value;
// res (source) carries conflict_count, distinct_colors and proper_coloring.
// A transaction moves at a rising edge with valid and ready both high.
// cfg_we/cfg_wdata write vertex_count; write it only while the block is idle.
//
// Clear graph and set color take effect at acceptance; set edge runs through
// the EDGE_RD and EDGE_WR states (read-modify-write of one adjacency row in the
// row RAM). Evaluate walks one adjacency row per cycle, n = min(vertex_count,
// MAX_VERTICES) rows, through the four-stage count pipeline; the result shows,
// and req.ready returns, together once the pipeline drains and the output
// register is free. Only evaluate yields a result.
//
// Reset clears the adjacency store at once through per-row valid bits; no
// clearing pass runs. Vertex colors are undefined until written.
// The result waits in an output register; while res is stalled the block still
// accepts and executes load commands, and a finished evaluation holds until
// the register is free.
// Depends on gcfe_pkg, gcfe_req_if, gcfe_rsp_if, gcfe_ctrl and gcfe_dp.

module graph_coloring_fitness_eval_core #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [gcfe_pkg::VC_W-1:0] cfg_wdata,
    gcfe_req_if.sink                  req,
    gcfe_rsp_if.source                res
);
    import gcfe_pkg::*;

    gcfe_ctl_t ctl;
    gcfe_sts_t sts;

    // Sequencing
    gcfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_cmd   (req.cmd),
        .in_ready (req.ready),
        .ctl      (ctl),
        .sts      (sts)
    );

    // Stores and scoring
    gcfe_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .vertex_a        (req.vertex_a),
        .vertex_b        (req.vertex_b),
        .color_value     (req.color_value),
        .ctl             (ctl),
        .sts             (sts),
        .out_valid       (res.valid),
        .out_ready       (res.ready),
        .conflict_count  (res.conflict_count),
        .distinct_colors (res.distinct_colors),
        .proper_coloring (res.proper_coloring)
    );

endmodule

// ===== rtl/gcfe_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module gcfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gcfe_ctrl.sv =====
// Controller state machine: decodes requests and sequences edge updates
// and evaluations. Depends on gcfe_pkg.

module gcfe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [gcfe_pkg::CMD_W-1:0] in_cmd,
    output logic                in_ready,
    output gcfe_pkg::gcfe_ctl_t ctl,
    input  gcfe_pkg::gcfe_sts_t sts
);
    import gcfe_pkg::*;

    gcfe_state_t state_reg;
    gcfe_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_cmd)
                        CMD_CLEAR:
                        begin
                            ctl.clear_adj = 1'b1;
                        end
                        CMD_EDGE:
                        begin
                            // drop self loops and out-of-range ends
                            if (sts.edge_ok)
                            begin
                                ctl.latch_edge = 1'b1;
                                state_next     = ST_EDGE_RD;
                            end
                        end
                        CMD_COLOR:
                        begin
                            ctl.write_color = 1'b1;
                        end
                        CMD_EVAL:
                        begin
                            ctl.eval_start = 1'b1;
                            state_next     = ST_EVAL;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EDGE_RD:
            begin
                ctl.edge_rd = 1'b1;
                state_next  = ST_EDGE_WR;
            end
            ST_EDGE_WR:
            begin
                ctl.edge_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_EVAL:
            begin
                ctl.eval_issue = 1'b1;
                if (sts.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // hold until the pipeline is empty and the result slot is free
                if (sts.pipe_idle && sts.out_free)
                begin
                    ctl.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/gcfe_dp.sv =====
// Datapath: adjacency and color stores, row-per-cycle conflict pipeline,
// seen mask and result register. Depends on gcfe_pkg and gcfe_ram.

module gcfe_dp #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gcfe_pkg::VC_W-1:0]      cfg_wdata,
    input  logic [gcfe_pkg::VTX_W-1:0]     vertex_a,
    input  logic [gcfe_pkg::VTX_W-1:0]     vertex_b,
    input  logic [gcfe_pkg::COLOR_W-1:0]   color_value,
    input  gcfe_pkg::gcfe_ctl_t            ctl,
    output gcfe_pkg::gcfe_sts_t            sts,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [gcfe_pkg::CONFLICT_W-1:0] conflict_count,
    output logic [gcfe_pkg::DISTINCT_W-1:0] distinct_colors,
    output logic                           proper_coloring
);
    import gcfe_pkg::*;

    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int NW     = $clog2(MAX_VERTICES + 1);
    localparam int GROUPS = (MAX_VERTICES + 7) / 8;
    localparam int PADW   = GROUPS * 8;
    localparam logic [8:0] MAX9 = 9'(MAX_VERTICES);

    // Configuration
    logic [VC_W-1:0] vc_reg;

    // Request decode
    logic [8:0]    a9;
    logic [8:0]    b9;
    logic          a_ok;
    logic          b_ok;
    logic [VW-1:0] a_idx;
    logic [VW-1:0] b_idx;
    logic          a_lt_b;
    logic          color_we;

    // Edge update
    logic [VW-1:0]           edge_row_reg;
    logic [VW-1:0]           edge_bit_reg;
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic                    rd_rowv_reg;
    logic [VW-1:0]           adj_raddr;
    logic [MAX_VERTICES-1:0] adj_rdata;
    logic [MAX_VERTICES-1:0] adj_base;
    logic [MAX_VERTICES-1:0] adj_wdata;

    // Colors
    logic [COLOR_W-1:0] lane_color_reg [MAX_VERTICES];
    logic [COLOR_W-1:0] col_rdata;

    // Evaluation
    logic [8:0]              vc9;
    logic [8:0]              n_sat;
    logic [NW-1:0]           n_reg;
    logic [VW-1:0]           i_reg;
    logic                    issue;
    logic                    v1_reg;
    logic                    v2_reg;
    logic                    v3_reg;
    logic                    v4_reg;
    logic [MAX_VERTICES-1:0] eq_vec;
    logic [MAX_VERTICES-1:0] n_mask;
    logic [MAX_VERTICES-1:0] hits_reg;
    logic [PADW-1:0]         hits_pad;
    logic [3:0]              grp_next [GROUPS];
    logic [3:0]              grp_reg  [GROUPS];
    logic [NW-1:0]           rowcnt_next;
    logic [NW-1:0]           rowcnt_reg;
    logic [COLOR_CODES-1:0]  seen_reg;
    logic [DISTINCT_W-1:0]   distinct_reg;
    logic [CONFLICT_W-1:0]   conflict_reg;
    logic [CONFLICT_W:0]     conflict_sum;

    // Result register
    logic                  out_valid_reg;
    logic [CONFLICT_W-1:0] out_conflict_reg;
    logic [DISTINCT_W-1:0] out_distinct_reg;
    logic                  out_proper_reg;

    // Vertex count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= VC_RESET;
        end
        else if (cfg_we)
        begin
            vc_reg <= cfg_wdata;
        end
    end

    // Decode vertex ends: range check and store index
    assign a9       = {3'b000, vertex_a};
    assign b9       = {3'b000, vertex_b};
    assign a_ok     = a9 < MAX9;
    assign b_ok     = b9 < MAX9;
    assign a_idx    = a9[VW-1:0];
    assign b_idx    = b9[VW-1:0];
    assign a_lt_b   = vertex_a < vertex_b;
    assign color_we = ctl.write_color && a_ok;

    // Latch the upper-triangle position of a new edge
    always_ff @(posedge clk)
    begin
        if (ctl.latch_edge)
        begin
            edge_row_reg <= a_lt_b ? a_idx : b_idx;
            edge_bit_reg <= a_lt_b ? b_idx : a_idx;
        end
    end

    // Row valid bits: clear on reset and clear graph, set on edge write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (ctl.clear_adj)
        begin
            row_valid_reg <= '0;
        end
        else if (ctl.edge_wr)
        begin
            row_valid_reg[edge_row_reg] <= 1'b1;
        end
    end

    // Sample the valid bit of the row being read
    always_ff @(posedge clk)
    begin
        rd_rowv_reg <= row_valid_reg[adj_raddr];
    end

    assign adj_raddr = ctl.edge_rd ? edge_row_reg : i_reg;
    assign adj_base  = rd_rowv_reg ? adj_rdata : '0;
    assign adj_wdata = adj_base | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << edge_bit_reg);

    gcfe_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (ctl.edge_wr),
        .waddr (edge_row_reg),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    gcfe_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAX_VERTICES)
    ) u_color_ram (
        .clk   (clk),
        .we    (color_we),
        .waddr (a_idx),
        .wdata (color_value),
        .raddr (i_reg),
        .rdata (col_rdata)
    );

    // Per-lane color copies for the parallel compare
    always_ff @(posedge clk)
    begin
        if (color_we)
        begin
            lane_color_reg[a_idx] <= color_value;
        end
    end

    // Vertex count clamped to the store size
    assign vc9   = {2'b00, vc_reg};
    assign n_sat = (vc9 > MAX9) ? MAX9 : vc9;
    assign issue = ctl.eval_issue && (n_reg != '0);

    assign sts.edge_ok    = a_ok && b_ok && (vertex_a != vertex_b);
    assign sts.last_issue = (n_reg == '0) || ((NW'(i_reg) + NW'(1)) == n_reg);
    assign sts.pipe_idle  = !(v1_reg || v2_reg || v3_reg || v4_reg);
    assign sts.out_free   = !out_valid_reg || out_ready;

    // Row counter and stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg  <= '0;
            n_reg  <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ctl.eval_start)
            begin
                i_reg <= '0;
                n_reg <= n_sat[NW-1:0];
            end
            else if (issue)
            begin
                i_reg <= i_reg + VW'(1);
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage 1: same-color lanes inside the active vertex range
    always_comb
    begin
        for (int j = 0; j < MAX_VERTICES; j++)
        begin
            eq_vec[j] = lane_color_reg[j] == col_rdata;
            n_mask[j] = NW'(j) < n_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hits_reg <= adj_base & eq_vec & n_mask;
    end

    // Stage 2: popcount in groups of eight
    assign hits_pad = PADW'(hits_reg);

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < 8; k++)
            begin
                grp_next[g] = grp_next[g] + 4'(hits_pad[g*8 + k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    // Stage 3: sum the group counts
    always_comb
    begin
        rowcnt_next = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            rowcnt_next = rowcnt_next + NW'(grp_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        rowcnt_reg <= rowcnt_next;
    end

    // Stage 4: saturating conflict accumulate
    assign conflict_sum = {1'b0, conflict_reg} + (CONFLICT_W+1)'(rowcnt_reg);

    // Score accumulators: seen mask, distinct colors, conflicts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            distinct_reg <= '0;
            conflict_reg <= '0;
        end
        else if (ctl.eval_start)
        begin
            seen_reg     <= '0;
            distinct_reg <= '0;
            conflict_reg <= '0;
        end
        else
        begin
            if (v1_reg && !seen_reg[col_rdata])
            begin
                seen_reg[col_rdata] <= 1'b1;
                if (distinct_reg != DISTINCT_MAX)
                begin
                    distinct_reg <= distinct_reg + DISTINCT_W'(1);
                end
            end
            if (v4_reg)
            begin
                if (conflict_sum > {1'b0, CONFLICT_MAX})
                begin
                    conflict_reg <= CONFLICT_MAX;
                end
                else
                begin
                    conflict_reg <= conflict_sum[CONFLICT_W-1:0];
                end
            end
        end
    end

    // Result register: load at the end of an evaluation, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_result)
        begin
            out_conflict_reg <= conflict_reg;
            out_distinct_reg <= distinct_reg;
            out_proper_reg   <= conflict_reg == '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign conflict_count  = out_conflict_reg;
    assign distinct_colors = out_distinct_reg;
    assign proper_coloring = out_proper_reg;

endmodule

// ===== rtl/gcfe_checker.sv =====
// Port-level checks on the graph coloring conflict counter, bound to the top.
// Depends on gcfe_pkg and graph_coloring_fitness_eval_core.

module gcfe_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic [gcfe_pkg::CMD_W-1:0]      req_cmd,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [gcfe_pkg::CONFLICT_W-1:0] res_conflict,
    input logic [gcfe_pkg::DISTINCT_W-1:0] res_distinct,
    input logic                            res_proper
);
    import gcfe_pkg::*;

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_conflict)
            && $stable(res_distinct) && $stable(res_proper))
        else $error("stalled result changed");

    // Flag agrees with the count
    a_proper_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_proper == (res_conflict == '0))
        else $error("proper_coloring disagrees with conflict_count");

    // Evaluate makes the block busy
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_cmd == CMD_EVAL |=> !req_ready)
        else $error("request taken during evaluation");

    // Load commands make no result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_cmd != CMD_EVAL && !res_valid |=> !res_valid)
        else $error("result after a load command");

    // A new result follows a busy cycle
    a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !$past(req_ready))
        else $error("result raised without an evaluation");

endmodule

bind graph_coloring_fitness_eval_core gcfe_checker u_gcfe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_cmd      (req.cmd),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_conflict (res.conflict_count),
    .res_distinct (res.distinct_colors),
    .res_proper   (res.proper_coloring)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for graph_coloring_fitness_eval_core: a scoreboard class scores
// every accepted request and checks each returned score against its own conflict predictor.
// Depends on gcfe_pkg, gcfe_req_if, gcfe_rsp_if and the core RTL.

module testbench;
    import gcfe_pkg::*;

    localparam int NUM_VERTICES   = 64;
    localparam int DRAIN_CYCLES   = 80;    // outlasts the longest evaluation
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [CONFLICT_W-1:0] conflict_count;
        logic [DISTINCT_W-1:0] distinct_colors;
        logic                  proper_coloring;
    } coloring_score_t;

    // Tracks graph, colors and vertex count; predicts and checks scores
    class coloring_scoreboard;
        logic [NUM_VERTICES-1:0] adj_rows [NUM_VERTICES];
        logic [COLOR_W-1:0]      vertex_color [NUM_VERTICES];
        logic [VC_W-1:0]         vertex_count;
        coloring_score_t         awaited_scores [$];
        int                      requests_seen;
        int                      scores_checked;
        int                      mismatches;
        int                      worst_conflicts;

        function new();
            foreach (adj_rows[r]) adj_rows[r] = '0;
            foreach (vertex_color[r]) vertex_color[r] = '0;
            vertex_count    = VC_RESET;
            requests_seen   = 0;
            scores_checked  = 0;
            mismatches      = 0;
            worst_conflicts = 0;
        endfunction

        // Apply one accepted request; queue a score for evaluate
        function void record_request(gcfe_cmd_t op, logic [VTX_W-1:0] va,
                                     logic [VTX_W-1:0] vb, logic [COLOR_W-1:0] color);
            logic [COLOR_CODES-1:0] seen;
            int                     n;
            int                     conflicts;
            int                     distinct;
            coloring_score_t        score;
            requests_seen++;
            case (op)
                CMD_CLEAR: foreach (adj_rows[r]) adj_rows[r] = '0;
                CMD_EDGE:
                begin
                    adj_rows[va][vb] = 1'b1;
                    adj_rows[vb][va] = 1'b1;
                end
                CMD_COLOR: vertex_color[va] = color;
                default:
                begin
                    n         = (vertex_count > NUM_VERTICES) ? NUM_VERTICES : vertex_count;
                    seen      = '0;
                    conflicts = 0;
                    distinct  = 0;
                    for (int i = 0; i < n; i++)
                    begin
                        if (!seen[vertex_color[i]])
                        begin
                            seen[vertex_color[i]] = 1'b1;
                            distinct++;
                        end
                        for (int j = i + 1; j < n; j++)
                            if (adj_rows[i][j] && vertex_color[i] == vertex_color[j])
                                conflicts++;
                    end
                    if (conflicts > CONFLICT_MAX) conflicts = int'(CONFLICT_MAX);
                    if (distinct > DISTINCT_MAX) distinct = int'(DISTINCT_MAX);
                    if (conflicts > worst_conflicts) worst_conflicts = conflicts;
                    score.conflict_count  = CONFLICT_W'(conflicts);
                    score.distinct_colors = DISTINCT_W'(distinct);
                    score.proper_coloring = (conflicts == 0);
                    awaited_scores.push_back(score);
                end
            endcase
        endfunction

        // Compare one returned score with the oldest prediction
        function void check_score(logic [CONFLICT_W-1:0] conflicts,
                                  logic [DISTINCT_W-1:0] distinct, logic proper);
            coloring_score_t want;
            if (awaited_scores.size() == 0)
            begin
                $display("%0t: unexpected score conflicts=%0d distinct=%0d proper=%0d",
                         $time, conflicts, distinct, proper);
                mismatches++;
            end
            else
            begin
                want = awaited_scores.pop_front();
                scores_checked++;
                if (conflicts !== want.conflict_count)
                begin
                    $display("%0t: conflict_count expected %0d actual %0d",
                             $time, want.conflict_count, conflicts);
                    mismatches++;
                end
                if (distinct !== want.distinct_colors)
                begin
                    $display("%0t: distinct_colors expected %0d actual %0d",
                             $time, want.distinct_colors, distinct);
                    mismatches++;
                end
                if (proper !== want.proper_coloring)
                begin
                    $display("%0t: proper_coloring expected %0d actual %0d",
                             $time, want.proper_coloring, proper);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_we;
    logic [VC_W-1:0] cfg_wdata;

    gcfe_req_if req_ch ();
    gcfe_rsp_if res_ch ();

    coloring_scoreboard scores = new();

    int src_gap_max    = 6;
    int sink_gap_max   = 6;
    bit sink_long_hold = 1'b0;
    int quiet_cycles   = 0;
    int phases_run     = 0;

    graph_coloring_fitness_eval_core #(
        .MAX_VERTICES(NUM_VERTICES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .req      (req_ch),
        .res      (res_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Observe transactions on both channels; end the run if the block goes quiet
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            scores.record_request(gcfe_cmd_t'(req_ch.cmd), req_ch.vertex_a,
                                  req_ch.vertex_b, req_ch.color_value);
        if (rst_n && res_ch.valid && res_ch.ready)
            scores.check_score(res_ch.conflict_count, res_ch.distinct_colors,
                               res_ch.proper_coloring);
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, no transaction for %0d cycles",
                     $time, WATCHDOG_LIMIT);
            $display("graph_coloring_fitness_eval_core verification failed");
            $finish;
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request
    initial
    begin : sink_driver
        int gap;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_long_hold)
            begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                sink_long_hold = 1'b0;
            end
            else
            begin
                gap = $urandom_range(0, sink_gap_max);
                if (gap > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid && res_ch.ready) && !sink_long_hold);
        end
    end

    // Offer one request after a random gap; return at the falling edge after acceptance
    task automatic send_request(gcfe_cmd_t op, logic [VTX_W-1:0] va, logic [VTX_W-1:0] vb,
                                logic [COLOR_W-1:0] color);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= op;
        req_ch.vertex_a    <= va;
        req_ch.vertex_b    <= vb;
        req_ch.color_value <= color;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Drop valid, wait for every score, then let the block finish any load
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (scores.awaited_scores.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Pick a vertex, mostly among the ones an evaluation walks
    function automatic logic [VTX_W-1:0] pick_vertex(int n_used);
        if (n_used > 0 && $urandom_range(0, 3) != 0)
            return VTX_W'($urandom_range(0, n_used - 1));
        return VTX_W'($urandom_range(0, NUM_VERTICES - 1));
    endfunction

    // Write vertex_count while idle, then run a block of random requests
    task automatic run_phase(logic [VC_W-1:0] vc, int palette, int eval_pct, int items,
                             bit pressure);
        int                 n_used;
        int                 roll;
        gcfe_cmd_t          op;
        logic [COLOR_W-1:0] color;
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= vc;
        @(negedge clk);
        cfg_we <= 1'b0;
        scores.vertex_count = vc;
        n_used = (vc > NUM_VERTICES) ? NUM_VERTICES : vc;
        case (phases_run % 4)
            0:       begin src_gap_max = 6; sink_gap_max = 6; end
            1:       begin src_gap_max = 0; sink_gap_max = 6; end
            2:       begin src_gap_max = 6; sink_gap_max = 0; end
            default: begin src_gap_max = 0; sink_gap_max = 0; end
        endcase
        if (pressure)
        begin
            src_gap_max    = 0;
            sink_long_hold = 1'b1;
        end
        phases_run++;
        for (int k = 0; k < items; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = CMD_CLEAR;
            else if (roll < 3 + eval_pct)
                op = CMD_EVAL;
            else if (roll % 3 != 0)
                op = CMD_EDGE;
            else
                op = CMD_COLOR;
            if ($urandom_range(0, 9) == 0)
                color = COLOR_W'($urandom_range(0, COLOR_CODES - 1));
            else
                color = COLOR_W'($urandom_range(1, palette));
            send_request(op, pick_vertex(n_used), pick_vertex(n_used), color);
        end
    endtask

    initial
    begin : stimulus
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_CLEAR;
        req_ch.vertex_a    = '0;
        req_ch.vertex_b    = '0;
        req_ch.color_value = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Color every vertex so no evaluation reads an unwritten color
        for (int v = 0; v < NUM_VERTICES; v++)
            send_request(CMD_COLOR, VTX_W'(v), VTX_W'($urandom),
                         COLOR_W'($urandom_range(1, 64)));

        // Empty graph, duplicate edge, self loop, color codes 0, 64 and 127
        send_request(CMD_EVAL, VTX_W'($urandom), VTX_W'($urandom), COLOR_W'($urandom));
        send_request(CMD_EDGE, 6'd0, 6'd63, COLOR_W'($urandom));
        send_request(CMD_EDGE, 6'd63, 6'd0, COLOR_W'($urandom));
        send_request(CMD_EDGE, 6'd5, 6'd5, COLOR_W'($urandom));
        send_request(CMD_EDGE, 6'd1, 6'd2, COLOR_W'($urandom));
        send_request(CMD_EDGE, 6'd62, 6'd63, COLOR_W'($urandom));
        send_request(CMD_COLOR, 6'd0, VTX_W'($urandom), 7'd0);
        send_request(CMD_COLOR, 6'd63, VTX_W'($urandom), 7'd127);
        send_request(CMD_COLOR, 6'd62, VTX_W'($urandom), 7'd127);
        send_request(CMD_COLOR, 6'd1, VTX_W'($urandom), 7'd64);
        send_request(CMD_COLOR, 6'd2, VTX_W'($urandom), 7'd64);
        send_request(CMD_COLOR, 6'd5, VTX_W'($urandom), 7'd64);
        send_request(CMD_EVAL, VTX_W'($urandom), VTX_W'($urandom), COLOR_W'($urandom));
        send_request(CMD_EDGE, 6'd0, 6'd1, COLOR_W'($urandom));
        send_request(CMD_COLOR, 6'd0, VTX_W'($urandom), 7'd64);
        send_request(CMD_EVAL, VTX_W'($urandom), VTX_W'($urandom), COLOR_W'($urandom));
        // Clearing the graph keeps the colors
        send_request(CMD_CLEAR, VTX_W'($urandom), VTX_W'($urandom), COLOR_W'($urandom));
        send_request(CMD_EVAL, VTX_W'($urandom), VTX_W'($urandom), COLOR_W'($urandom));
        send_request(CMD_EDGE, 6'd42, 6'd21, COLOR_W'($urandom));
        send_request(CMD_COLOR, 6'd21, VTX_W'($urandom), 7'd64);
        send_request(CMD_COLOR, 6'd42, VTX_W'($urandom), 7'd64);
        send_request(CMD_EVAL, VTX_W'($urandom), VTX_W'($urandom), COLOR_W'($urandom));

        // Zero, small, oversized and full vertex counts, dense and sparse palettes
        run_phase(7'd0, 127, 20, 30, 1'b0);
        run_phase(7'd1, 4, 20, 30, 1'b0);
        run_phase(7'd2, 2, 20, 40, 1'b0);
        run_phase(7'd127, 3, 15, 50, 1'b0);
        run_phase(7'd64, 2, 30, 50, 1'b1);
        run_phase(7'd64, 1, 10, 60, 1'b0);
        run_phase(VC_W'($urandom_range(3, 63)), 6, 15, 50, 1'b0);
        run_phase(7'd64, 127, 15, 50, 1'b0);
        settle();

        $display("Covered %0d requests over %0d vertex_count settings, %0d scores checked,",
                 scores.requests_seen, phases_run, scores.scores_checked);
        $display("largest conflict count %0d, with random and long result stalls.",
                 scores.worst_conflicts);
        if (scores.mismatches == 0 && scores.awaited_scores.size() == 0)
            $display("graph_coloring_fitness_eval_core verification clean");
        else
            $display("graph_coloring_fitness_eval_core verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/gcfe_pkg.sv
rtl/gcfe_req_if.sv
rtl/gcfe_rsp_if.sv
rtl/gcfe_ram.sv
rtl/gcfe_ctrl.sv
rtl/gcfe_dp.sv
rtl/graph_coloring_fitness_eval_core.sv
rtl/gcfe_checker.sv
verif/testbench.sv
